### rtl/bbal_pkg.sv
// ----------------------------------------------------------------------------
// bbal_pkg
// Shared types and constants of the block bitmap allocator: beat payloads,
// status codes, opcodes, register indexes and map word geometry.
// ----------------------------------------------------------------------------
package bbal_pkg;

  // Field widths
  localparam int BLK_W      = 12;  // block number on the ports
  localparam int CFG_W      = 13;  // configuration register width
  localparam int CFG_IDX_W  = 2;   // configuration register index width
  localparam int CFG_SPAN   = 1 << CFG_W;

  // Map word geometry
  localparam int WORD_W     = 64;
  localparam int WBIT_W     = $clog2(WORD_W);

  localparam int MAX_BLOCKS_DEF = 4096;

  // Opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } status_t;

  typedef struct packed {
    logic             opcode;
    logic [BLK_W-1:0] block_number;
  } in_beat_t;

  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] result_block;
  } out_beat_t;

endpackage

### rtl/bbal_ffs.sv
// ----------------------------------------------------------------------------
// bbal_ffs
// Find-first-set: index of the lowest set bit of a vector, plus a hit flag.
// ----------------------------------------------------------------------------
module bbal_ffs #(
  parameter int W  = 64,
  parameter int IW = (W > 1) ? $clog2(W) : 1
) (
  input  logic [W-1:0]  vec,
  output logic          found,
  output logic [IW-1:0] idx
);

  // Scan from the top so the lowest set bit wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        found = 1'b1;
        idx   = IW'(i);
      end
    end
  end

endmodule

### rtl/block_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator_core
// First-fit block allocator over a used-bit map held in a word memory.
// ----------------------------------------------------------------------------
//  channel | dir | ports                        | payload
//  --------+-----+------------------------------+--------------------------
//  in      | in  | in_valid / in_ready          | in_data  (opcode, block)
//  out     | out | out_valid / out_ready        | out_data (status, block)
//  cfg     | in  | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// An allocate steps IDLE, FIND, CHECK, DONE; while the candidate word has no
// free bit inside the window, CHECK goes back to FIND for the next candidate:
// one read of the word memory per candidate word, through its single read port.
// A free steps IDLE, FIND, CHECK, DONE; a free flagged out of range, or an
// allocate that finds no candidate word, goes IDLE, FIND, DONE.
// One request is worked on at a time; the next is taken once the result sits
// in the output register, which holds it while out_ready is low.
// Reset clears the per-word valid and full flags at once; no clearing pass.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_core #(
  parameter int MAX_BLOCKS = bbal_pkg::MAX_BLOCKS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  bbal_pkg::in_beat_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output bbal_pkg::out_beat_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bbal_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bbal_pkg::CFG_W-1:0]           cfg_data
);
  import bbal_pkg::*;

  // Map geometry; blocks past the 13-bit register range are unreachable
  localparam int MAP_BLOCKS = (MAX_BLOCKS < CFG_SPAN) ? MAX_BLOCKS : CFG_SPAN;
  localparam int MAP_CAP    = (MAP_BLOCKS >= CFG_SPAN) ? CFG_SPAN - 1 : MAP_BLOCKS;
  localparam int NWORDS     = (MAP_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WA_W       = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_CHECK,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic                op_r, op_nxt;
  logic [BLK_W-1:0]    blk_r, blk_nxt;
  logic [WA_W-1:0]     cur_w_r, cur_w_nxt;
  out_beat_t           pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_data_r, out_data_nxt;
  logic [NWORDS-1:0]   vld_r, vld_nxt;
  logic [NWORDS-1:0]   full_r, full_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [CFG_W-1:0]    total_r, reserved_r;

  // Word memory
  logic [WORD_W-1:0]   mem [NWORDS];
  logic [WORD_W-1:0]   mem_q;
  logic                mem_we, mem_re;
  logic [WA_W-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0]   mem_wdata;

  // Derived limits
  logic [CFG_W-1:0]    lim, lim_m1, blk_ext;
  logic                no_room, blk_bad;
  logic [WA_W-1:0]     start_w, last_w;

  // Search helpers
  logic [NWORDS-1:0]   cand;
  logic                cand_hit;
  logic [WA_W-1:0]     cand_w;
  logic [WORD_W-1:0]   word, lo_mask, hi_mask, free_bits;
  logic                bit_hit;
  logic [WBIT_W-1:0]   bit_idx;
  logic                out_load;
  logic [CFG_W-1:0]    res_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= CFG_W'(4096);
      reserved_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TOTAL:    total_r    <= cfg_data;
        REG_RESERVED: reserved_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Usable window [reserved, lim)
  assign lim     = (total_r > CFG_W'(MAP_CAP)) ? CFG_W'(MAP_CAP) : total_r;
  assign lim_m1  = lim - CFG_W'(1);
  assign no_room = (reserved_r >= lim);
  assign start_w = WA_W'(reserved_r >> WBIT_W);
  assign last_w  = WA_W'(lim_m1 >> WBIT_W);
  assign blk_ext = CFG_W'(blk_r);
  assign blk_bad = (blk_ext >= lim) || (blk_ext < reserved_r);

  // Candidate words: not full, inside the window, at or past the scan point
  always_comb begin
    for (int w = 0; w < NWORDS; w++) begin
      cand[w] = !full_r[w] && (WA_W'(w) >= cur_w_r) && (WA_W'(w) <= last_w);
    end
  end

  bbal_ffs #(.W(NWORDS), .IW(WA_W)) u_word_ffs (
    .vec   (cand),
    .found (cand_hit),
    .idx   (cand_w)
  );

  // Word read back; a never-written word reads as all free
  assign word    = rd_vld_r ? mem_q : '0;
  assign lo_mask = (cur_w_r == start_w) ? ({WORD_W{1'b1}} << reserved_r[WBIT_W-1:0])
                                        : {WORD_W{1'b1}};
  assign hi_mask = (cur_w_r == last_w)
                 ? ({WORD_W{1'b1}} >> (WBIT_W'(WORD_W - 1) - lim_m1[WBIT_W-1:0]))
                 : {WORD_W{1'b1}};
  assign free_bits = ~word & lo_mask & hi_mask;

  bbal_ffs #(.W(WORD_W), .IW(WBIT_W)) u_bit_ffs (
    .vec   (free_bits),
    .found (bit_hit),
    .idx   (bit_idx)
  );

  assign res_ext  = CFG_W'({cur_w_r, bit_idx});
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Sequencer: next-state and datapath
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    blk_nxt       = blk_r;
    cur_w_nxt     = cur_w_r;
    pend_nxt      = pend_r;
    vld_nxt       = vld_r;
    full_nxt      = full_r;
    rd_vld_nxt    = rd_vld_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = cur_w_r;
    mem_raddr     = cur_w_r;
    mem_wdata     = word;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.opcode;
          blk_nxt   = in_data.block_number;
          cur_w_nxt = start_w;
          state_nxt = S_FIND;
        end
      end

      // Pick a word and issue its read, or settle the request at once
      S_FIND: begin
        if (op_r == OP_ALLOC) begin
          if (no_room || !cand_hit) begin
            pend_nxt  = '{status: ST_FULL, result_block: '0};
            state_nxt = S_DONE;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = cand_w;
            cur_w_nxt  = cand_w;
            rd_vld_nxt = vld_r[cand_w];
            state_nxt  = S_CHECK;
          end
        end else begin
          if (blk_bad) begin
            pend_nxt  = '{status: ST_RANGE, result_block: blk_r};
            state_nxt = S_DONE;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = WA_W'(blk_ext >> WBIT_W);
            cur_w_nxt  = WA_W'(blk_ext >> WBIT_W);
            rd_vld_nxt = vld_r[WA_W'(blk_ext >> WBIT_W)];
            state_nxt  = S_CHECK;
          end
        end
      end

      // Modify the word and write it back, or go on to the next word, or settle the request
      S_CHECK: begin
        if (op_r == OP_ALLOC) begin
          if (bit_hit) begin
            mem_we            = 1'b1;
            mem_wdata         = word | (WORD_W'(1) << bit_idx);
            vld_nxt[cur_w_r]  = 1'b1;
            full_nxt[cur_w_r] = &mem_wdata;
            pend_nxt          = '{status: ST_OK, result_block: res_ext[BLK_W-1:0]};
            state_nxt         = S_DONE;
          end else if (cur_w_r == last_w) begin
            pend_nxt  = '{status: ST_FULL, result_block: '0};
            state_nxt = S_DONE;
          end else begin
            cur_w_nxt = cur_w_r + WA_W'(1);
            state_nxt = S_FIND;
          end
        end else begin
          if (word[blk_r[WBIT_W-1:0]]) begin
            mem_we            = 1'b1;
            mem_wdata         = word & ~(WORD_W'(1) << blk_r[WBIT_W-1:0]);
            vld_nxt[cur_w_r]  = 1'b1;
            full_nxt[cur_w_r] = 1'b0;
            pend_nxt          = '{status: ST_OK, result_block: blk_r};
          end else begin
            pend_nxt = '{status: ST_ALREADY_FREE, result_block: blk_r};
          end
          state_nxt = S_DONE;
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (out_load) begin
          out_data_nxt = pend_r;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      full_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
      full_r      <= full_nxt;
    end
    op_r       <= op_nxt;
    blk_r      <= blk_nxt;
    cur_w_r    <= cur_w_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
    rd_vld_r   <= rd_vld_nxt;
  end

  // Map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // Checks
  a_we_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CHECK))
    else $error("map write outside CHECK");

  a_re_in_find: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |=> (state_r == S_CHECK))
    else $error("map read not followed by CHECK");

  a_accept_find: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_FIND))
    else $error("accepted request did not start a search");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (full_r[$past(mem_waddr)] == (&$past(mem_wdata))))
    else $error("full flag out of step with written word");

  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

endmodule
